// ===== sv/command_line_router_defines.svh =====
// assertion macros shared by the command line router modules
`ifndef COMMAND_LINE_ROUTER_DEFINES_SVH
`define COMMAND_LINE_ROUTER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/clr_pkg.sv =====
// shared types, codes and the slot decode function of the command line router
package clr_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int TASK_COUNT     = 16;
    localparam int SLOT_COUNT     = 62;
    localparam int SLOT_W         = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_KEY      = 1'b1;

    localparam logic [7:0] KEY_ENTER = 8'h0A;
    localparam logic [7:0] LINE_MARK = 8'h25;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UP_LO  = 8'h41;
    localparam logic [7:0] CH_UP_HI  = 8'h5A;
    localparam logic [7:0] CH_LOW_LO = 8'h61;
    localparam logic [7:0] CH_LOW_HI = 8'h7A;
    localparam logic [7:0] UP_OFFSET  = 8'd55;
    localparam logic [7:0] LOW_OFFSET = 8'd61;

    // result status codes
    localparam logic [1:0] ST_BYTE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_CANNOT  = 2'd2;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_REG   = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_ENTER = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        slot_t      slot;
        logic [3:0] task_id;
    } cmd_t;

    function automatic slot_t slot_of(input logic [7:0] c);
        slot_t s;
        s.ok  = 1'b1;
        s.idx = '0;
        if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
            s.idx = SLOT_W'(c - CH_DIG_LO);
        end else if (c >= CH_UP_LO && c <= CH_UP_HI) begin
            s.idx = SLOT_W'(c - UP_OFFSET);
        end else if (c >= CH_LOW_LO && c <= CH_LOW_HI) begin
            s.idx = SLOT_W'(c - LOW_OFFSET);
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== sv/clr_front.sv =====
// front end: accepts input beats, classifies them and queues commands
`include "command_line_router_defines.svh"

module clr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_opcode,
    input  logic [7:0]    s_char_code,
    input  logic [3:0]    s_task_id,
    output clr_pkg::cmd_t q_cmd,
    output logic          q_valid,
    input  logic          q_pop
);
    localparam int PTR_W = $clog2(clr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(clr_pkg::QUEUE_DEPTH + 1);

    clr_pkg::cmd_t   fifo_mem [clr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    clr_pkg::cmd_t  dec_cmd;
    clr_pkg::slot_t dec_slot;
    logic           keep;
    logic           push;

    always_comb begin
        dec_slot        = clr_pkg::slot_of(s_char_code);
        dec_cmd.code    = s_char_code;
        dec_cmd.slot    = dec_slot;
        dec_cmd.task_id = s_task_id;
        if (s_opcode == clr_pkg::OP_KEY) begin
            dec_cmd.kind = (s_char_code == clr_pkg::KEY_ENTER) ? clr_pkg::CMD_ENTER
                                                                : clr_pkg::CMD_KEY;
        end else begin
            dec_cmd.kind = clr_pkg::CMD_REG;
        end
    end

    // register beats with no slot or an out-of-range task are dropped here
    assign keep = (s_opcode == clr_pkg::OP_KEY) ||
                  (dec_slot.ok && (int'(s_task_id) < clr_pkg::TASK_COUNT));

    assign s_ready = (count_reg != CNT_W'(clr_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

    `CLR_ASSERT_SAME(a_pop_needs_entry, q_pop, count_reg != '0, "pop from empty queue")
    `CLR_ASSERT_NEXT(a_push_counts, push && !q_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

// ===== sv/clr_back.sv =====
// back end: line buffer, owner table, command dispatch and result register
`include "command_line_router_defines.svh"

module clr_back #(
    parameter int LINE_BYTES = clr_pkg::LINE_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  clr_pkg::cmd_t q_cmd,
    input  logic          q_valid,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic [3:0]    m_receiver,
    output logic [1:0]    m_status,
    output logic          m_last
);
    localparam int IDX_W = $clog2(LINE_BYTES);
    localparam int LEN_W = $clog2(LINE_BYTES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_SEND   = 2'd2;

    logic [7:0] line_mem  [LINE_BYTES];
    logic [3:0] owner_mem [clr_pkg::SLOT_COUNT];

    logic [1:0]                    state_reg, state_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [LEN_W-1:0]              cnt_reg, cnt_next;
    logic [LEN_W-1:0]              drain_len_reg, drain_len_next;
    logic [7:0]                    first_reg, first_next;
    clr_pkg::slot_t                cmd_slot_reg, cmd_slot_next;
    logic [clr_pkg::SLOT_COUNT-1:0] marks_reg;
    logic [7:0]                    rd_data_reg;
    logic [3:0]                    owner_q_reg;

    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic [3:0] m_receiver_reg;
    logic [1:0] m_status_reg;
    logic       m_last_reg;

    logic             out_free;
    logic             owner_we;
    logic             line_we;
    logic             emit;
    logic [7:0]       emit_byte;
    logic [3:0]       emit_rcv;
    logic [1:0]       emit_status;
    logic             emit_last;
    logic             last_hit;
    logic             mark_ok;
    logic [LEN_W-1:0] cnt_inc;
    logic [LEN_W-1:0] rd_sel;
    logic [IDX_W-1:0] rd_addr;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && out_free;
    assign owner_we = q_pop && (q_cmd.kind == clr_pkg::CMD_REG);
    assign mark_ok  = cmd_slot_reg.ok && marks_reg[cmd_slot_reg.idx];
    assign cnt_inc  = cnt_reg + 1'b1;
    assign last_hit = (cnt_inc == drain_len_reg);

    // read one ahead while beats flow so the buffer keeps up with the output
    assign rd_sel  = (state_reg == S_SEND && out_free) ? cnt_inc : cnt_reg;
    assign rd_addr = rd_sel[IDX_W-1:0];

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        drain_len_next = drain_len_reg;
        first_next     = first_reg;
        cmd_slot_next  = cmd_slot_reg;
        line_we        = 1'b0;
        emit           = 1'b0;
        emit_byte      = 8'd0;
        emit_rcv       = 4'd0;
        emit_status    = clr_pkg::ST_INVALID;
        emit_last      = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    case (q_cmd.kind)
                        clr_pkg::CMD_KEY: begin
                            if (len_reg == LEN_W'(LINE_BYTES)) begin
                                len_next = '0;
                                emit     = 1'b1;
                            end else begin
                                line_we  = 1'b1;
                                len_next = len_reg + 1'b1;
                                if (len_reg == LEN_W'(0)) begin
                                    first_next = q_cmd.code;
                                end
                                if (len_reg == LEN_W'(1)) begin
                                    cmd_slot_next = q_cmd.slot;
                                end
                            end
                        end
                        clr_pkg::CMD_ENTER: begin
                            len_next = '0;
                            if (len_reg == LEN_W'(0) || first_reg != clr_pkg::LINE_MARK) begin
                                emit = 1'b1;
                            end else if (len_reg == LEN_W'(1) || !mark_ok) begin
                                emit        = 1'b1;
                                emit_status = clr_pkg::ST_CANNOT;
                            end else begin
                                state_next     = S_LOOKUP;
                                cnt_next       = LEN_W'(1);
                                drain_len_next = len_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                state_next = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_byte   = rd_data_reg;
                    emit_rcv    = owner_q_reg;
                    emit_status = clr_pkg::ST_BYTE;
                    emit_last   = last_hit;
                    cnt_next    = cnt_inc;
                    if (last_hit) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            marks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (owner_we) begin
                marks_reg[q_cmd.slot.idx] <= 1'b1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        drain_len_reg <= drain_len_next;
        first_reg     <= first_next;
        cmd_slot_reg  <= cmd_slot_next;
        if (emit) begin
            m_out_byte_reg <= emit_byte;
            m_receiver_reg <= emit_rcv;
            m_status_reg   <= emit_status;
            m_last_reg     <= emit_last;
        end
    end

    // line buffer and owner table: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_mem[len_reg[IDX_W-1:0]] <= q_cmd.code;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (owner_we) begin
            owner_mem[q_cmd.slot.idx] <= q_cmd.task_id;
        end
        owner_q_reg <= owner_mem[cmd_slot_reg.idx];
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_receiver = m_receiver_reg;
    assign m_status   = m_status_reg;
    assign m_last     = m_last_reg;

    `CLR_ASSERT_SAME(a_send_in_range, state_reg == S_SEND, cnt_reg < drain_len_reg, "send index past line end")
    `CLR_ASSERT_SAME(a_error_is_last, m_valid_reg && m_status_reg != clr_pkg::ST_BYTE, m_last_reg, "error beat without last")
    `CLR_ASSERT_SAME(a_len_bounded, 1'b1, len_reg <= LEN_W'(LINE_BYTES), "line length beyond buffer")
    `CLR_ASSERT_NEXT(a_drain_ends, state_reg == S_SEND && out_free && last_hit, state_reg == S_IDLE, "drain did not return to idle")

endmodule

// ===== sv/command_line_router.sv =====
// Timing: a register or key beat is executed when the back end pops it from the queue; error
// results appear on m_ the cycle after that; command bytes are emitted from S_SEND after S_LOOKUP.
// Throughput: one beat per cycle while the back end is idle and m_ is free; a valid command line
// holds it in S_LOOKUP for owner and line buffer reads, then 1 byte a cycle in S_SEND if m_ is free.
// Reset (aresetn, synchronous): clears registered marks, line length, queue and output valid;
// line buffer and owner table are not cleared and no clearing pass runs.
module command_line_router #(
    parameter int LINE_BYTES = clr_pkg::LINE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_char_code,
    input  logic [3:0] s_task_id,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [3:0] m_receiver,
    output logic [1:0] m_status,
    output logic       m_last
);
    clr_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_pop;

    clr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_char_code (s_char_code),
        .s_task_id   (s_task_id),
        .q_cmd       (q_cmd),
        .q_valid     (q_valid),
        .q_pop       (q_pop)
    );

    clr_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_cmd      (q_cmd),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_receiver (m_receiver),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule
